[rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int AXES     = 3;
	localparam int CRD_W    = 32;               // Q16.16 coordinate
	localparam int HALF_W   = 31;               // non-negative half extent
	localparam int NUM_W    = 35;               // bound - origin, signed
	localparam int MAG_W    = 34;               // |bound - origin|
	localparam int FRAC     = 16;
	localparam int DIVD_W   = MAG_W + FRAC;     // scaled dividend
	localparam int DIV_BITS = 31;               // quotient bits below saturation
	localparam int REM_W    = CRD_W + DIV_BITS; // holds divisor << 31
	// divider: input register, one stage per quotient bit, output register
	localparam int DIV_LAT  = DIV_BITS + 2;
	// s1 + divider + order + merge
	localparam int PIPE_DEPTH = 1 + DIV_LAT + 2;

	localparam logic signed [CRD_W-1:0] T_MAX = 32'sh7fff_ffff;
	localparam logic signed [CRD_W-1:0] T_MIN = 32'sh8000_0000;

	localparam int          ADDR_W          = 2;
	localparam logic [ADDR_W-1:0] REG_ACCEPT_ADDR = 2'd0;

	typedef struct packed {
		logic                    par;   // direction zero on this axis
		logic                    miss;  // parallel and origin outside slab
		logic signed [CRD_W-1:0] tlo;
		logic signed [CRD_W-1:0] thi;
	} lane_res_t;

endpackage

[rtl/rbst_div.sv]
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined signed Q16.16 divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module rbst_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rbst_pkg::NUM_W-1:0] num,
	input  logic signed [rbst_pkg::CRD_W-1:0] den,
	output logic signed [rbst_pkg::CRD_W-1:0] quo
);
	import rbst_pkg::*;

	logic [MAG_W-1:0]  num_mag;
	logic [CRD_W-1:0]  den_mag;
	logic [NUM_W-1:0]  num_neg;

	logic [DIVD_W-1:0] divd_s1;
	logic [CRD_W-1:0]  dvsr_s1;
	logic              neg_s1;

	logic [REM_W-1:0]    rem_q [DIV_BITS];
	logic [CRD_W-1:0]    dvsr_q [DIV_BITS];
	logic [DIV_BITS-1:0] qbits_q [DIV_BITS];
	logic                neg_q [DIV_BITS];
	logic                ovf_q [DIV_BITS];

	assign num_neg = -num;
	assign num_mag = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
	assign den_mag = den[CRD_W-1] ? -den : den;

	always_ff @(posedge clk) begin
		if (en) begin
			divd_s1 <= {num_mag, {FRAC{1'b0}}};
			dvsr_s1 <= den_mag;
			neg_s1  <= num[NUM_W-1] ^ den[CRD_W-1];
		end
	end

	genvar k;
	generate
		for (k = 0; k < DIV_BITS; k++) begin : g_stage
			logic [REM_W-1:0]    rem_in;
			logic [CRD_W-1:0]    dvsr_in;
			logic [DIV_BITS-1:0] qbits_in;
			logic                neg_in;
			logic                ovf_in;
			logic [REM_W-1:0]    shifted;
			logic                take;

			if (k == 0) begin : g_first
				// quotient of 2^31 or more saturates; low bits then unused
				assign rem_in   = REM_W'(divd_s1);
				assign dvsr_in  = dvsr_s1;
				assign qbits_in = '0;
				assign neg_in   = neg_s1;
				assign ovf_in   = (REM_W'(divd_s1) >= {dvsr_s1, {DIV_BITS{1'b0}}});
			end else begin : g_next
				assign rem_in   = rem_q[k-1];
				assign dvsr_in  = dvsr_q[k-1];
				assign qbits_in = qbits_q[k-1];
				assign neg_in   = neg_q[k-1];
				assign ovf_in   = ovf_q[k-1];
			end

			assign shifted = REM_W'(dvsr_in) << (DIV_BITS - 1 - k);
			assign take    = (rem_in >= shifted);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k]   <= take ? rem_in - shifted : rem_in;
					dvsr_q[k]  <= dvsr_in;
					qbits_q[k] <= qbits_in | (DIV_BITS'(take) << (DIV_BITS - 1 - k));
					neg_q[k]   <= neg_in;
					ovf_q[k]   <= ovf_in;
				end
			end
		end
	endgenerate

	logic [CRD_W-1:0] mag_ext;
	assign mag_ext = {1'b0, qbits_q[DIV_BITS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_q[DIV_BITS-1])
				quo <= neg_q[DIV_BITS-1] ? T_MIN : T_MAX;
			else
				quo <= neg_q[DIV_BITS-1] ? -$signed(mag_ext) : $signed(mag_ext);
		end
	end

endmodule

[rtl/rbst_lane.sv]
// ----------------------------------------------------------------------------
// rbst_lane
// One axis: slab bounds, parallel check, entry and exit parameters.
// ----------------------------------------------------------------------------
module rbst_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rbst_pkg::CRD_W-1:0] origin,
	input  logic signed [rbst_pkg::CRD_W-1:0] dir,
	input  logic signed [rbst_pkg::CRD_W-1:0] center,
	input  logic        [rbst_pkg::HALF_W-1:0] half,
	output rbst_pkg::lane_res_t               res
);
	import rbst_pkg::*;

	typedef struct packed {
		logic par;
		logic miss;
	} side_t;

	logic signed [NUM_W-1:0] o_ext, c_ext, h_ext;
	logic signed [NUM_W-1:0] num_lo_s1, num_hi_s1;
	logic signed [CRD_W-1:0] dir_s1;
	logic signed [CRD_W-1:0] t1, t2;
	side_t                   side_in;
	side_t                   dly_q [DIV_LAT];

	assign o_ext = NUM_W'(origin);
	assign c_ext = NUM_W'(center);
	assign h_ext = $signed({{(NUM_W-HALF_W){1'b0}}, half});

	always_ff @(posedge clk) begin
		if (en) begin
			num_lo_s1 <= c_ext - h_ext - o_ext;
			num_hi_s1 <= c_ext + h_ext - o_ext;
			dir_s1    <= dir;
		end
	end

	// origin below lo means lo - o > 0, origin above hi means hi - o < 0
	assign side_in.par  = (dir_s1 == '0);
	assign side_in.miss = (dir_s1 == '0) && ((num_lo_s1 > 0) || num_hi_s1[NUM_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= side_in;
			for (int i = 1; i < DIV_LAT; i++)
				dly_q[i] <= dly_q[i-1];
		end
	end

	rbst_div u_div_lo (.clk(clk), .en(en), .num(num_lo_s1), .den(dir_s1), .quo(t1));
	rbst_div u_div_hi (.clk(clk), .en(en), .num(num_hi_s1), .den(dir_s1), .quo(t2));

	always_ff @(posedge clk) begin
		if (en) begin
			res.par  <= dly_q[DIV_LAT-1].par;
			res.miss <= dly_q[DIV_LAT-1].miss;
			res.tlo  <= (t1 > t2) ? t2 : t1;
			res.thi  <= (t1 > t2) ? t1 : t2;
		end
	end

endmodule

[rtl/rbst_merge.sv]
// ----------------------------------------------------------------------------
// rbst_merge
// Folds the per-axis intervals into one and decides hit.
// ----------------------------------------------------------------------------
module rbst_merge (
	input  logic                clk,
	input  logic                en,
	input  logic                accept_behind,
	input  rbst_pkg::lane_res_t lanes [rbst_pkg::AXES],
	output logic                hit
);
	import rbst_pkg::*;

	logic signed [CRD_W-1:0] tmin, tmax;
	logic                    miss;
	logic signed [CRD_W-1:0] tmin_s1, tmax_s1;
	logic                    miss_s1;

	always_comb begin
		tmin = accept_behind ? T_MIN : '0;
		tmax = T_MAX;
		miss = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			miss = miss | lanes[a].miss;
			if (!lanes[a].par) begin
				if (lanes[a].tlo > tmin)
					tmin = lanes[a].tlo;
				if (lanes[a].thi < tmax)
					tmax = lanes[a].thi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s1 <= tmin;
			tmax_s1 <= tmax;
			miss_s1 <= miss;
		end
	end

	// touching interval counts as a hit
	assign hit = !miss_s1 && (tmin_s1 <= tmax_s1);

endmodule

[rtl/ray_box_slab_test.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box slab test, three axis lanes and a merge stage.
// ----------------------------------------------------------------------------
// Path: an accepted word passes lane s1, the dividers, the lane order and merge registers, then the hit register.
// Throughput: one word per cycle; the 31-stage bit-per-cycle dividers in each
//   lane set the depth, and the whole pipe holds while the output is stalled.
// Reset: arst_n clears valid bits and accept_behind_q; no clearing pass.
module ray_box_slab_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_origin_x,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_origin_y,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_origin_z,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_dir_x,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_dir_y,
	input  logic signed [rbst_pkg::CRD_W-1:0]  ray_dir_z,
	input  logic signed [rbst_pkg::CRD_W-1:0]  box_center_x,
	input  logic signed [rbst_pkg::CRD_W-1:0]  box_center_y,
	input  logic signed [rbst_pkg::CRD_W-1:0]  box_center_z,
	input  logic        [rbst_pkg::HALF_W-1:0] box_half_x,
	input  logic        [rbst_pkg::HALF_W-1:0] box_half_y,
	input  logic        [rbst_pkg::HALF_W-1:0] box_half_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rbst_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import rbst_pkg::*;

	logic                  en;
	logic                  accept_behind_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  hit_c;
	lane_res_t             lanes [AXES];

	assign pready = 1'b1;
	assign prdata = (paddr == REG_ACCEPT_ADDR) ? {31'b0, accept_behind_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			accept_behind_q <= 1'b0;
		else if (psel && penable && pwrite && pready && (paddr == REG_ACCEPT_ADDR))
			accept_behind_q <= pwdata[0];
	end

	// pipe moves unless a finished word sits stalled at the output
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[PIPE_DEPTH-2:0], in_valid};
			out_valid <= vld_q[PIPE_DEPTH-1];
		end
	end

	rbst_lane u_lane_x (.clk(clk), .en(en), .origin(ray_origin_x), .dir(ray_dir_x),
		.center(box_center_x), .half(box_half_x), .res(lanes[0]));
	rbst_lane u_lane_y (.clk(clk), .en(en), .origin(ray_origin_y), .dir(ray_dir_y),
		.center(box_center_y), .half(box_half_y), .res(lanes[1]));
	rbst_lane u_lane_z (.clk(clk), .en(en), .origin(ray_origin_z), .dir(ray_dir_z),
		.center(box_center_z), .half(box_half_z), .res(lanes[2]));

	rbst_merge u_merge (.clk(clk), .en(en), .accept_behind(accept_behind_q),
		.lanes(lanes), .hit(hit_c));

	always_ff @(posedge clk) begin
		if (en)
			hit <= hit_c;
	end

endmodule

[rtl/rbst_checker.sv]
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks on the slab test block, bound to the top level.
// ----------------------------------------------------------------------------
module rbst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        hit,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [rbst_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);
	import rbst_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit))
		else $error("stalled output word changed");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while output free");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input open while output word stalled");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == REG_ACCEPT_ADDR)
		##1 (psel && !pwrite && paddr == REG_ACCEPT_ADDR)
		|-> prdata == {31'b0, $past(pwdata[0])})
		else $error("register readback mismatch");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);

[tb/tb_ray_box_slab_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test
// Self-checking bench for the ray versus box slab test: directed corner rays
// and random rays are pushed through valid/stall with random idling, and each
// hit word is checked against a behavioral slab-test predictor.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test;
	import rbst_pkg::*;

	typedef struct packed {
		logic signed [CRD_W-1:0] org_x, org_y, org_z;
		logic signed [CRD_W-1:0] dir_x, dir_y, dir_z;
		logic signed [CRD_W-1:0] ctr_x, ctr_y, ctr_z;
		logic [HALF_W-1:0] half_x, half_y, half_z;
	} ray_box_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = PIPE_DEPTH + 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ray_box_t cur_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ray_box_t pending_rays[$];
	logic expected_hits[$];
	logic accept_neg = 1'b0;
	int error_count = 0;
	int idle_cycles = 0;
	bit idling_on = 1'b1;
	bit stim_done = 1'b0;
	int in_gap = 0, out_gap = 0;

	ray_box_slab_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ray_origin_x(cur_word.org_x), .ray_origin_y(cur_word.org_y),
		.ray_origin_z(cur_word.org_z),
		.ray_dir_x(cur_word.dir_x), .ray_dir_y(cur_word.dir_y),
		.ray_dir_z(cur_word.dir_z),
		.box_center_x(cur_word.ctr_x), .box_center_y(cur_word.ctr_y),
		.box_center_z(cur_word.ctr_z),
		.box_half_x(cur_word.half_x), .box_half_y(cur_word.half_y),
		.box_half_z(cur_word.half_z),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint slab_t(longint num, longint den);
		longint q;
		q = (num * 65536) / den;
		if (q > longint'(T_MAX)) q = longint'(T_MAX);
		if (q < longint'(T_MIN)) q = longint'(T_MIN);
		return q;
	endfunction

	function automatic logic predict_hit(ray_box_t r, logic neg_ok);
		longint tmin, tmax, o, d, c, h, lo, hi, t1, t2, s;
		logic [CRD_W-1:0] ov[3], dv[3], cv[3];
		logic [HALF_W-1:0] hv[3];
		ov = '{r.org_x, r.org_y, r.org_z};
		dv = '{r.dir_x, r.dir_y, r.dir_z};
		cv = '{r.ctr_x, r.ctr_y, r.ctr_z};
		hv = '{r.half_x, r.half_y, r.half_z};
		tmin = neg_ok ? longint'(T_MIN) : 0;
		tmax = longint'(T_MAX);
		for (int a = 0; a < AXES; a++) begin
			o = longint'(signed'(ov[a]));
			d = longint'(signed'(dv[a]));
			c = longint'(signed'(cv[a]));
			h = longint'(hv[a]);
			lo = c - h;
			hi = c + h;
			if (d == 0) begin
				if (o < lo || o > hi) return 1'b0;
			end else begin
				t1 = slab_t(lo - o, d);
				t2 = slab_t(hi - o, d);
				if (t1 > t2) begin
					s = t1; t1 = t2; t2 = s;
				end
				if (t1 > tmin) tmin = t1;
				if (t2 < tmax) tmax = t2;
				if (tmin > tmax) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// driver: prediction is made at acceptance so register changes stay ordered
	logic accepted_q;
	always @(posedge clk) begin
		accepted_q <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			expected_hits.push_back(predict_hit(cur_word, accept_neg));
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_q) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_rays.size() > 0) begin
					cur_word <= pending_rays.pop_front();
					in_valid <= 1'b1;
					if (idling_on && $urandom_range(0, 9) == 0)
						in_gap = $urandom_range(1, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 11) == 0) begin
				out_gap = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic want;
		if (out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("hit word with nothing expected");
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want)
					report_mismatch($sformatf("hit %b, expected %b", hit, want));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic reg_write(logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_ACCEPT_ADDR; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		accept_neg = val[0];
	endtask

	task automatic wait_idle();
		while (pending_rays.size() > 0 || in_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_crd();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return 32'($signed($urandom_range(0, 400)) - 200);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CRD_W-1:0] rand_dir();
		if ($urandom_range(0, 5) == 0) return '0;
		return rand_crd();
	endfunction

	function automatic logic [HALF_W-1:0] rand_half();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? '1 : '0;
			1: return HALF_W'($urandom_range(0, 8 << 16));
			default: return HALF_W'($urandom);
		endcase
	endfunction

	function automatic ray_box_t rand_ray();
		ray_box_t r;
		r.org_x = rand_crd(); r.org_y = rand_crd(); r.org_z = rand_crd();
		r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
		r.half_x = rand_half(); r.half_y = rand_half(); r.half_z = rand_half();
		// aim most rays at the box so slabs overlap often
		if ($urandom_range(0, 2) != 0) begin
			r.ctr_x = r.org_x + 32'(r.dir_x * $urandom_range(0, 3));
			r.ctr_y = r.org_y + 32'(r.dir_y * $urandom_range(0, 3));
			r.ctr_z = r.org_z + 32'(r.dir_z * $urandom_range(0, 3));
		end else begin
			r.ctr_x = rand_crd(); r.ctr_y = rand_crd(); r.ctr_z = rand_crd();
		end
		return r;
	endfunction

	function automatic ray_box_t mk_ray(logic [31:0] o, logic [31:0] d, logic [31:0] c,
		logic [30:0] h);
		ray_box_t r;
		r.org_x = o; r.org_y = 0; r.org_z = 0;
		r.dir_x = d; r.dir_y = 0; r.dir_z = 0;
		r.ctr_x = c; r.ctr_y = 0; r.ctr_z = 0;
		r.half_x = h; r.half_y = 31'h10000; r.half_z = 31'h10000;
		return r;
	endfunction

	task automatic push_directed();
		ray_box_t r;
		pending_rays.push_back(mk_ray(0, 32'h10000, 32'h50000, 31'h10000));
		pending_rays.push_back(mk_ray(0, 32'hffff0000, 32'h50000, 31'h10000));
		pending_rays.push_back(mk_ray(32'h20000, 0, 0, 31'h20000));   // parallel, on bound
		pending_rays.push_back(mk_ray(32'h20001, 0, 0, 31'h20000));   // parallel, just out
		pending_rays.push_back(mk_ray(32'h8000_0000, 1, 32'h7fff_ffff, '1)); // saturation
		pending_rays.push_back(mk_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, '1));
		pending_rays.push_back(mk_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0));
		pending_rays.push_back(mk_ray(0, 1, 0, 0));                    // touching slab
		r = mk_ray(0, 32'h10000, 32'h20000, 31'h10000);                // two slabs just meet
		r.dir_y = 32'h10000; r.ctr_y = 32'h40000; r.half_y = 31'h10000;
		pending_rays.push_back(r);
		r.ctr_y = 32'h40001;
		pending_rays.push_back(r);
		r = '1;
		pending_rays.push_back(r);
		pending_rays.push_back('0);
		pending_rays.push_back(mk_ray(32'h50000, 32'h10000, 0, 31'h10000)); // box behind
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		push_directed();
		wait_idle();
		reg_write(32'h1);
		push_directed();
		for (int i = 0; i < 500; i++) pending_rays.push_back(rand_ray());
		wait_idle();
		reg_write(32'hffff_fffe);
		for (int i = 0; i < 500; i++) pending_rays.push_back(rand_ray());
		wait_idle();
		reg_write(32'h1);
		for (int i = 0; i < 200; i++) pending_rays.push_back(rand_ray());
		wait_idle();
		reg_write(32'h0);
		idling_on = 1'b0;
		for (int i = 0; i < 250; i++) pending_rays.push_back(rand_ray());
		wait_idle();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[filelist.f]
rtl/rbst_pkg.sv
rtl/rbst_div.sv
rtl/rbst_lane.sv
rtl/rbst_merge.sv
rtl/ray_box_slab_test.sv
rtl/rbst_checker.sv
tb/tb_ray_box_slab_test.sv
